>>> src/aes_block_encrypt_top_assert.svh
// Assertion macros for the AES block encryption top level.
// Depends on nothing; included by aes_block_encrypt_top.sv.
`ifndef AES_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_TOP_ASSERT_SVH

// Same-cycle implication on the rising clock, off during reset.
`define AES_ASSERT_NOW(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication on the rising clock, off during reset.
`define AES_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

>>> src/aes_pkg.sv
// Shared types, constants and the S-box for the AES block encryption block.
// Depends on nothing.
package aes_pkg;

    localparam int KEY_STORE_WORDS_DEF = 32;
    localparam logic [3:0] NUM_ROUNDS_RST = 4'd10;
    localparam logic [3:0] NUM_ROUNDS_MIN = 4'd10;
    localparam logic [3:0] NUM_ROUNDS_MAX = 4'd14;
    localparam logic OP_KEY_WRITE = 1'b0;
    localparam logic OP_ENCRYPT   = 1'b1;

    typedef struct packed {
        logic        op;
        logic [4:0]  key_index;
        logic [63:0] key_data;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_in;

    typedef struct packed {
        logic [63:0] cipher_low;
        logic [63:0] cipher_high;
    } t_out;

    typedef struct packed {
        logic first;
        logic last;
    } t_round_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] v);
        logic [7:0] r;
        case (v)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

>>> src/aes_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/aes_round.sv
// Shared AES round: SubBytes, ShiftRows, MixColumns, AddRoundKey; first
// round adds the key only, last skips MixColumns. Depends on aes_pkg.
module aes_round (
    input  logic [127:0]        i_state,
    input  logic [127:0]        i_key,
    input  aes_pkg::t_round_ctl i_ctl,
    output logic [127:0]        o_state
);
    import aes_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[8*i +: 8];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[4*r+c] = sbox(s[4*r + ((c + r) % 4)]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[c]    = t[c] ^ (t[c]^t[4+c]^t[8+c]^t[12+c]) ^ xtime(t[c] ^ t[4+c]);
            m[4+c]  = t[4+c] ^ (t[c]^t[4+c]^t[8+c]^t[12+c]) ^ xtime(t[4+c] ^ t[8+c]);
            m[8+c]  = t[8+c] ^ (t[c]^t[4+c]^t[8+c]^t[12+c]) ^ xtime(t[8+c] ^ t[12+c]);
            m[12+c] = t[12+c] ^ (t[c]^t[4+c]^t[8+c]^t[12+c]) ^ xtime(t[12+c] ^ t[c]);
        end
        for (int i = 0; i < 16; i++) begin
            if (i_ctl.first) begin
                o_state[8*i +: 8] = s[i] ^ i_key[8*i +: 8];
            end else if (i_ctl.last) begin
                o_state[8*i +: 8] = t[i] ^ i_key[8*i +: 8];
            end else begin
                o_state[8*i +: 8] = m[i] ^ i_key[8*i +: 8];
            end
        end
    end
endmodule

>>> src/aes_block_encrypt_top.sv
// Top level of the AES block encryption engine: sequencer, key store, result register.
// Depends on aes_pkg, aes_ram, aes_round and aes_block_encrypt_top_assert.svh.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data): op 0 writes one 64-bit
//   round-key word, op 1 encrypts one 128-bit block. Round-key words for round n
//   sit at indexes 2n and 2n+1 and must be written before an encryption uses them.
//   Config channel (i_cfg_valid, o_cfg_ready, i_cfg_data): sets the round count
//   (10 to 14; below 10 acts as 10, above 14 as 14). Write it only while idle.
//   Output channel (o_out_valid, i_out_stall, o_out_data): one ciphertext per
//   encryption; key writes give none.
//   An encryption applies one round per cycle in the shared round unit, except
//   while its last round waits on a stalled receiver. The input stalls during an
//   encryption, so a new block is taken only once the last one is done. Round
//   keys are read ahead from two RAM banks; the key store port sets the round pace.
//   While the receiver stalls, the result holds in the output register; a further
//   encryption runs up to its last round and waits there.
//   Reset clears the sequencer, the result valid and sets num_rounds to 10; the
//   key store keeps whatever it held and needs no clearing.
module aes_block_encrypt_top #(
    parameter int KEY_STORE_WORDS = aes_pkg::KEY_STORE_WORDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  aes_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output aes_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_data
);
    import aes_pkg::*;

    `include "aes_block_encrypt_top_assert.svh"

    localparam int BANK_DEPTH = (KEY_STORE_WORDS + 1) / 2;
    localparam int ADDR_W = $clog2(BANK_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state       r_state, n_state;
    logic [3:0]   r_rnd, n_rnd;
    logic [3:0]   r_nr;
    logic [127:0] r_st, n_st;
    logic         r_ov, n_ov;
    t_out         r_out, n_out;
    logic         r_lo_ok, r_hi_ok;

    logic [3:0]   nr_eff;
    logic         in_acc;
    logic         enc_acc;
    logic         key_we;
    logic         hold;
    logic [3:0]   rd_rnd;
    logic [63:0]  rd_lo, rd_hi;
    logic [127:0] rkey;
    logic [127:0] rnd_out;
    t_round_ctl   ctl;

    assign nr_eff = (r_nr < NUM_ROUNDS_MIN) ? NUM_ROUNDS_MIN :
                    (r_nr > NUM_ROUNDS_MAX) ? NUM_ROUNDS_MAX : r_nr;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc  = i_in_valid && !o_in_stall;
    assign enc_acc = in_acc && (i_in_data.op == OP_ENCRYPT);
    assign key_we  = in_acc && (i_in_data.op == OP_KEY_WRITE) &&
                     ({1'b0, i_in_data.key_index} < 6'(KEY_STORE_WORDS));

    assign hold   = (r_state == ST_RUN) && (r_rnd == nr_eff) && r_ov && i_out_stall;
    assign rd_rnd = enc_acc ? 4'd0 : (hold ? r_rnd : r_rnd + 4'd1);

    aes_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH), .ADDR_W(ADDR_W)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (key_we && !i_in_data.key_index[0]),
        .i_waddr (ADDR_W'(i_in_data.key_index[4:1])),
        .i_wdata (i_in_data.key_data),
        .i_raddr (ADDR_W'(rd_rnd)),
        .o_rdata (rd_lo)
    );

    aes_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH), .ADDR_W(ADDR_W)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (key_we && i_in_data.key_index[0]),
        .i_waddr (ADDR_W'(i_in_data.key_index[4:1])),
        .i_wdata (i_in_data.key_data),
        .i_raddr (ADDR_W'(rd_rnd)),
        .o_rdata (rd_hi)
    );

    always_ff @(posedge i_clk) begin
        r_lo_ok <= ({1'b0, rd_rnd, 1'b0} < 6'(KEY_STORE_WORDS));
        r_hi_ok <= ({1'b0, rd_rnd, 1'b1} < 6'(KEY_STORE_WORDS));
    end

    assign rkey = {r_hi_ok ? rd_hi : 64'd0, r_lo_ok ? rd_lo : 64'd0};
    assign ctl.first = (r_rnd == 4'd0);
    assign ctl.last  = (r_rnd == nr_eff);

    aes_round u_round (
        .i_state (r_st),
        .i_key   (rkey),
        .i_ctl   (ctl),
        .o_state (rnd_out)
    );

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_st    = r_st;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (enc_acc) begin
                    n_state = ST_RUN;
                    n_rnd   = 4'd0;
                    n_st    = {i_in_data.block_high, i_in_data.block_low};
                end
            end
            ST_RUN: begin
                if (!hold) begin
                    if (r_rnd == nr_eff) begin
                        n_state = ST_IDLE;
                        n_ov    = 1'b1;
                        n_out.cipher_low  = rnd_out[63:0];
                        n_out.cipher_high = rnd_out[127:64];
                    end else begin
                        n_st  = rnd_out;
                        n_rnd = r_rnd + 4'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= 4'd0;
            r_ov    <= 1'b0;
            r_nr    <= NUM_ROUNDS_RST;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_nr <= i_cfg_data;
            end
        end
        r_st  <= n_st;
        r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `AES_ASSERT_NEXT(a_enc_start, i_clk, i_rst_n, enc_acc, (r_state == ST_RUN) && (r_rnd == 4'd0), "encryption did not start at round zero")
    `AES_ASSERT_NOW(a_rnd_bound, i_clk, i_rst_n, r_state == ST_RUN, r_rnd <= nr_eff, "round counter ran past the round count")
    `AES_ASSERT_NOW(a_out_rise, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_RUN, "result appeared without a finished encryption")
endmodule
